// File: design/euler_angles_to_quaternion_macros.svh
// Assertion macros used by the top-level design file.
`ifndef EULER_ANGLES_TO_QUATERNION_MACROS_SVH
`define EULER_ANGLES_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define EATQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define EATQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EATQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define EATQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/eatq_pkg.sv
package eatq_pkg;

   localparam int AngleWidth = 16;
   localparam int AccWidth   = 34;
   localparam int Q30Width   = 32;
   localparam int Q15Width   = 16;

   typedef logic signed [AngleWidth-1:0] angle_type;
   typedef logic signed [AccWidth-1:0]   acc_type;
   typedef logic signed [Q30Width-1:0]   q30_type;
   typedef logic signed [Q15Width-1:0]   q15_type;

   // Cosine and sine of one half angle.
   typedef struct packed {
      q30_type c;
      q30_type s;
   } cs_type;

   localparam q30_type CordicGain = 32'sd652032874;
   localparam int      Q15Max     = 32767;

   // Stage angle atan(2^-i), pi = 2^31.
   function automatic acc_type atan_step(input int idx);
      acc_type v;
      case (idx)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10679838;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q.30 product, rounded half up.
   function automatic q30_type mulq(input q30_type a, input q30_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
      return p[61:30];
   endfunction

   // Q.30 value to Q1.15 with rounding and symmetric saturation.
   function automatic q15_type to_q15(input logic signed [Q30Width:0] v);
      logic signed [Q30Width+1:0] t;
      logic signed [18:0]         r;
      t = {v[Q30Width], v} + 34'sd16384;
      r = t[33:15];
      if (r > 19'sd32767) begin
         return q15_type'(Q15Max);
      end else if (r < -19'sd32767) begin
         return q15_type'(-Q15Max);
      end
      return r[15:0];
   endfunction

endpackage

// File: design/eatq_cordic_lane.sv
module eatq_cordic_lane import eatq_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic      clock,
   input  logic      enable,
   input  angle_type angle,
   output cs_type    result
);

   acc_type acc_ff [CORDIC_STAGES];
   q30_type x_ff   [CORDIC_STAGES];
   q30_type y_ff   [CORDIC_STAGES];

   // One rotation per register stage.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      acc_type acc_prev;
      q30_type x_prev;
      q30_type y_prev;
      acc_type acc_in;
      q30_type x_in;
      q30_type y_in;

      if (i == 0) begin : g_first
         assign acc_prev = {{(AccWidth-AngleWidth-15){angle[AngleWidth-1]}}, angle, 15'b0};
         assign x_prev   = CordicGain;
         assign y_prev   = '0;
      end else begin : g_next
         assign acc_prev = acc_ff[i-1];
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
      end

      always_comb begin
         if (!acc_prev[AccWidth-1]) begin
            x_in   = x_prev - (y_prev >>> i);
            y_in   = y_prev + (x_prev >>> i);
            acc_in = acc_prev - atan_step(i);
         end else begin
            x_in   = x_prev + (y_prev >>> i);
            y_in   = y_prev - (x_prev >>> i);
            acc_in = acc_prev + atan_step(i);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            acc_ff[i] <= acc_in;
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
         end
      end
   end

   assign result.c = x_ff[CORDIC_STAGES-1];
   assign result.s = y_ff[CORDIC_STAGES-1];

endmodule

// File: design/eatq_merge.sv
module eatq_merge import eatq_pkg::*; (
   input  logic    clock,
   input  logic    enable,
   input  cs_type  pitch_cs,
   input  cs_type  yaw_cs,
   input  cs_type  roll_cs,
   output q15_type quat_w,
   output q15_type quat_x,
   output q15_type quat_y,
   output q15_type quat_z
);

   q30_type cc_ff, ss_ff, sc_ff, cs_ff;
   q30_type c3_ff, s3_ff;
   q30_type t_ff [8];
   q15_type w_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         // Pitch and yaw pair products.
         cc_ff <= mulq(pitch_cs.c, yaw_cs.c);
         ss_ff <= mulq(pitch_cs.s, yaw_cs.s);
         sc_ff <= mulq(pitch_cs.s, yaw_cs.c);
         cs_ff <= mulq(pitch_cs.c, yaw_cs.s);
         c3_ff <= roll_cs.c;
         s3_ff <= roll_cs.s;
         // Triple products with the roll pair.
         t_ff[0] <= mulq(cc_ff, c3_ff);
         t_ff[1] <= mulq(ss_ff, s3_ff);
         t_ff[2] <= mulq(ss_ff, c3_ff);
         t_ff[3] <= mulq(cc_ff, s3_ff);
         t_ff[4] <= mulq(sc_ff, c3_ff);
         t_ff[5] <= mulq(cs_ff, s3_ff);
         t_ff[6] <= mulq(cs_ff, c3_ff);
         t_ff[7] <= mulq(sc_ff, s3_ff);
         // Sums, rounding and saturation.
         w_ff <= to_q15(33'(t_ff[0]) - 33'(t_ff[1]));
         x_ff <= to_q15(33'(t_ff[2]) + 33'(t_ff[3]));
         y_ff <= to_q15(33'(t_ff[4]) + 33'(t_ff[5]));
         z_ff <= to_q15(33'(t_ff[6]) - 33'(t_ff[7]));
      end
   end

   assign quat_w = w_ff;
   assign quat_x = x_ff;
   assign quat_y = y_ff;
   assign quat_z = z_ff;

endmodule

// File: design/euler_angles_to_quaternion.sv
// Euler angles to unit quaternion. Each item carries three 16-bit binary
// angles (32768 stands for pi) and yields one quaternion (w, x, y, z) in Q1.15,
// saturated to plus or minus 32767. Three CORDIC lanes, one per angle, find the
// cosine and sine of the half angles side by side, and a merging stage forms
// the products. The pipeline takes one item every cycle while the result side
// does not stall. An item passes one register per CORDIC rotation plus the
// pair product, triple product and rounding registers of the merge, and the
// first of these is loaded at the edge at which the item is accepted. When the
// result side stalls, the whole pipeline holds, and input items are taken again
// as soon as the result is taken.
// Angles outside plus or minus pi must be wrapped by software.
`include "euler_angles_to_quaternion_macros.svh"
module euler_angles_to_quaternion import eatq_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
   output logic [63:0] rsp_tdata
);

   localparam int Depth = CORDIC_STAGES + 3;

   logic             enable;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;
   cs_type           roll_cs, pitch_cs, yaw_cs;
   q15_type          quat_w, quat_x, quat_y, quat_z;
   logic             no_min_code;

   // The pipeline moves whenever the output register is free or being taken.
   assign enable     = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = enable;

   assign vld_in = {vld_ff[Depth-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   eatq_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[15:0]),
      .result (roll_cs)
   );

   eatq_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[31:16]),
      .result (pitch_cs)
   );

   eatq_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[47:32]),
      .result (yaw_cs)
   );

   eatq_merge u_merge (
      .clock    (clock),
      .enable   (enable),
      .pitch_cs (pitch_cs),
      .yaw_cs   (yaw_cs),
      .roll_cs  (roll_cs),
      .quat_w   (quat_w),
      .quat_x   (quat_x),
      .quat_y   (quat_y),
      .quat_z   (quat_z)
   );

   assign rsp_tvalid = vld_ff[Depth-1];
   assign rsp_tdata  = {quat_z, quat_y, quat_x, quat_w};

   assign no_min_code = (quat_w != 16'h8000) && (quat_x != 16'h8000) &&
                        (quat_y != 16'h8000) && (quat_z != 16'h8000);

   // Saturation never lets the most negative code out.
   `EATQ_ASSERT_SAME(a_no_min_code, clock, reset, rsp_tvalid, no_min_code)
   // An accepted item enters the first pipeline stage.
   `EATQ_ASSERT_NEXT(a_item_enters, clock, reset, req_tvalid && req_tready, vld_ff[0])
   // Reset empties the pipeline.
   `EATQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   // A stalled result stays presented.
   `EATQ_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule
